>>> rtl/rpfc_pkg.sv
// rpfc_pkg: shared widths for the range prime factor census unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

  localparam int CNT_W = 11;
  localparam int TOT_W = 5;
  localparam int DIS_W = 4;

endpackage

`default_nettype wire

>>> rtl/rpfc_div.sv
// rpfc_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module rpfc_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [NUM_W-1:0] a,
  input  wire logic [DEN_W-1:0] b,
  output logic                  done,
  output logic      [NUM_W-1:0] quo,
  output logic      [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   r_sh;
  logic [DEN_W:0]   r_sub;
  logic             fits;

  always_comb begin
    r_sh  = {rem, quo[NUM_W-1]};
    r_sub = r_sh - {1'b0, den};
    fits  = (r_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo     <= a;
        den     <= b;
        rem     <= '0;
        cnt     <= CNT_W'(NUM_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rpfc_store.sv
// rpfc_store: per-number work memory, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module rpfc_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 33
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/range_prime_factor_census_unit.sv
// range_prime_factor_census_unit: segmented sieve census over one range per item
// depends on rpfc_pkg, rpfc_div, rpfc_store
//
// One item is a range [range_start, range_end]. A rejected range (end below
// start, or more than MAX_SPAN numbers) is answered in the next cycle with
// range_error set. Otherwise the unit fills its work memory with each number
// of the range, takes the integer square root of range_end bit by bit (folding
// range_start modulo 3 on the way), then walks every trial divisor p from 2 to
// sqrt(range_end)+1 with one shared VALUE_BITS-step divider: for each divisor
// it divides to find the first multiple in range, then divides each multiple
// in range once, and once more for each factor removed, plus two passes over
// the span (fill and count). busy stays high for the whole of an accepted
// item. The result is shown for exactly one cycle with valid high and cannot
// be held off.
`timescale 1ns / 1ps
`default_nettype none

module range_prime_factor_census_unit #(
  parameter int MAX_SPAN   = 1024,
  parameter int VALUE_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [VALUE_BITS-1:0]       range_start,
  input  wire logic [VALUE_BITS-1:0]       range_end,
  output logic                             valid,
  output logic [rpfc_pkg::CNT_W-1:0]       count_div_two_or_three,
  output logic [rpfc_pkg::CNT_W-1:0]       prime_count,
  output logic [rpfc_pkg::CNT_W-1:0]       count_two_distinct,
  output logic [rpfc_pkg::CNT_W-1:0]       count_three_or_four,
  output logic                             range_error
);

  localparam int V     = VALUE_BITS;
  localparam int SQ    = (V + 1) / 2;
  localparam int LW    = 2 * SQ;
  localparam int PW    = SQ + 1;
  localparam int XW    = 2 * PW;
  localparam int AW    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int CW    = $clog2(MAX_SPAN + 1);
  localparam int KW    = $clog2(SQ);
  localparam int TW    = rpfc_pkg::TOT_W;
  localparam int DW    = rpfc_pkg::DIS_W;
  localparam int NW    = rpfc_pkg::CNT_W;
  localparam int MW    = V + TW + DW;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SQRT, S_LIMIT, S_PSTART, S_PFIRST,
    S_XCHECK, S_XREAD, S_XDIV, S_FIN, S_DRAIN, S_OUT
  } state_t;

  state_t          state;
  logic [V-1:0]    lo, hi;
  logic [CW-1:0]   span, cnt;
  logic [SQ-1:0]   root;
  logic [KW-1:0]   k;
  logic [PW-1:0]   limit, p;
  logic [XW-1:0]   pp, x;
  logic [V-1:0]    w_rem;
  logic [TW-1:0]   w_tot;
  logic [DW-1:0]   w_dis;
  logic            hit;
  logic [1:0]      m3;
  logic            par;
  logic            rv;
  logic [NW-1:0]   c23, cpr, c2d, c34;

  logic            div_go, div_done;
  logic [V-1:0]    div_a, div_quo;
  logic [PW-1:0]   div_b, div_rem;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [MW-1:0]   wdata, rdata;

  logic            accept, bad;
  logic [V-1:0]    diff;
  logic [AW-1:0]   idx;
  logic [SQ-1:0]   sq_t;
  logic [2*SQ-1:0] sq_tt;
  logic [XW-1:0]   first_val;
  logic [V-1:0]    rd_rem;
  logic [TW-1:0]   rd_tot;
  logic [DW-1:0]   rd_dis;
  logic [TW-1:0]   tf;
  logic [DW-1:0]   df;
  logic [LW-1:0]   lo_pad;
  logic [2:0]      m3_sum;
  logic [1:0]      m3_fold;

  rpfc_div #(.NUM_W(V), .DEN_W(PW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .a(div_a), .b(div_b),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  rpfc_store #(.DEPTH(MAX_SPAN), .ADDR_W(AW), .DATA_W(MW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    accept    = start && !busy;
    diff      = range_end - range_start;
    bad       = (range_end < range_start) || (32'(diff) >= 32'(MAX_SPAN));
    idx       = AW'(x - XW'(lo));
    raddr     = (state == S_FIN) ? cnt[AW-1:0] : idx;
    sq_t      = root | (SQ'(1) << k);
    sq_tt     = {{SQ{1'b0}}, sq_t} * {{SQ{1'b0}}, sq_t};
    first_val = (div_rem == '0) ? XW'(lo) : XW'(lo) + XW'(p) - XW'(div_rem);
    rd_rem    = rdata[MW-1 -: V];
    rd_tot    = rdata[TW+DW-1:DW];
    rd_dis    = rdata[DW-1:0];
    tf        = (rd_rem > V'(1)) ? rd_tot + 1'b1 : rd_tot;
    df        = (rd_rem > V'(1)) ? rd_dis + 1'b1 : rd_dis;
    // base four digits sum to the value modulo 3
    lo_pad    = LW'(lo);
    m3_sum    = {1'b0, m3} + {1'b0, lo_pad[{k, 1'b0} +: 2]};
    m3_fold   = (m3_sum >= 3'd3) ? 2'(m3_sum - 3'd3) : m3_sum[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      valid  <= 1'b0;
      we     <= 1'b0;
      div_go <= 1'b0;
      rv     <= 1'b0;
    end else begin
      valid  <= 1'b0;
      we     <= 1'b0;
      div_go <= 1'b0;
      rv     <= 1'b0;

      // census accumulation, one entry per cycle behind the read
      if (rv) begin
        if (!par || m3 == 2'd0) c23 <= c23 + 1'b1;
        if (tf == TW'(1) && df == DW'(1)) cpr <= cpr + 1'b1;
        if (tf == TW'(2) && df == DW'(2)) c2d <= c2d + 1'b1;
        if (tf == TW'(3) || tf == TW'(4)) c34 <= c34 + 1'b1;
        m3  <= (m3 == 2'd2) ? 2'd0 : m3 + 1'b1;
        par <= ~par;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (bad) begin
              count_div_two_or_three <= '0;
              prime_count            <= '0;
              count_two_distinct     <= '0;
              count_three_or_four    <= '0;
              range_error            <= 1'b1;
              valid                  <= 1'b1;
            end else begin
              lo    <= range_start;
              hi    <= range_end;
              span  <= CW'(diff) + 1'b1;
              cnt   <= '0;
              busy  <= 1'b1;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          we    <= 1'b1;
          waddr <= cnt[AW-1:0];
          wdata <= {lo + V'(cnt), {TW{1'b0}}, {DW{1'b0}}};
          cnt   <= cnt + 1'b1;
          if (cnt == span - 1'b1) begin
            root  <= '0;
            k     <= KW'(SQ - 1);
            m3    <= 2'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (XW'(sq_tt) <= XW'(hi)) root <= sq_t;
          m3 <= m3_fold;
          k  <= k - 1'b1;
          if (k == '0) state <= S_LIMIT;
        end
        S_LIMIT: begin
          limit <= PW'(root) + 1'b1;
          p     <= PW'(2);
          state <= S_PSTART;
        end
        S_PSTART: begin
          if (p > limit) begin
            cnt   <= '0;
            c23   <= '0;
            cpr   <= '0;
            c2d   <= '0;
            c34   <= '0;
            par   <= lo[0];
            state <= S_FIN;
          end else begin
            pp     <= XW'(p) * XW'(p);
            div_a  <= lo;
            div_b  <= p;
            div_go <= 1'b1;
            state  <= S_PFIRST;
          end
        end
        S_PFIRST: begin
          if (div_done) begin
            x     <= (first_val < pp) ? pp : first_val;
            state <= S_XCHECK;
          end
        end
        S_XCHECK: begin
          if (x > XW'(hi)) begin
            p     <= p + 1'b1;
            state <= S_PSTART;
          end else begin
            state <= S_XREAD;
          end
        end
        S_XREAD: begin
          w_rem  <= rd_rem;
          w_tot  <= rd_tot;
          w_dis  <= rd_dis;
          hit    <= 1'b0;
          div_a  <= rd_rem;
          div_go <= 1'b1;
          state  <= S_XDIV;
        end
        S_XDIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              w_rem  <= div_quo;
              w_tot  <= w_tot + 1'b1;
              if (!hit) w_dis <= w_dis + 1'b1;
              hit    <= 1'b1;
              div_a  <= div_quo;
              div_go <= 1'b1;
            end else begin
              we    <= 1'b1;
              waddr <= idx;
              wdata <= {w_rem, w_tot, w_dis};
              x     <= x + XW'(p);
              state <= S_XCHECK;
            end
          end
        end
        S_FIN: begin
          rv  <= 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == span - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          count_div_two_or_three <= c23;
          prime_count            <= cpr;
          count_two_distinct     <= c2d;
          count_three_or_four    <= c34;
          range_error            <= 1'b0;
          valid                  <= 1'b1;
          busy                   <= 1'b0;
          state                  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rpfc_checker.sv
// rpfc_checker: port-level checks for range_prime_factor_census_unit
// depends on rpfc_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module rpfc_checker #(
  parameter int VALUE_BITS = 24
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [VALUE_BITS-1:0]       range_start,
  input wire logic [VALUE_BITS-1:0]       range_end,
  input wire logic                        valid,
  input wire logic [rpfc_pkg::CNT_W-1:0]  count_div_two_or_three,
  input wire logic [rpfc_pkg::CNT_W-1:0]  prime_count,
  input wire logic [rpfc_pkg::CNT_W-1:0]  count_two_distinct,
  input wire logic [rpfc_pkg::CNT_W-1:0]  count_three_or_four,
  input wire logic                        range_error
);

  // a result never shows while an item is still at work
  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result shown while busy");

  // a reversed range is rejected in the next cycle
  a_reversed: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (range_end < range_start)) |=> (valid && range_error))
    else $error("reversed range not rejected");

  // a rejected range reports zero counts
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && range_error) |-> (count_div_two_or_three == '0 &&
      prime_count == '0 && count_two_distinct == '0 &&
      count_three_or_four == '0))
    else $error("nonzero counts with range error");

  // a full census only ends an item that kept the unit busy
  a_census_after_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && !range_error) |-> $past(busy))
    else $error("census result without a busy item");

endmodule

bind range_prime_factor_census_unit rpfc_checker #(.VALUE_BITS(VALUE_BITS)) u_rpfc_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for range_prime_factor_census_unit
// depends on rpfc_pkg and the unit; a scoreboard class predicts each census
`timescale 1ns / 1ps

module tb_top;

  localparam int SPAN_MAX = 1024;
  localparam int VB = 24;
  localparam int FLAG_DEPTH = 4098;
  localparam logic [VB-1:0] TOP = '1;

  typedef struct packed {
    logic [rpfc_pkg::CNT_W-1:0] div23;
    logic [rpfc_pkg::CNT_W-1:0] primes;
    logic [rpfc_pkg::CNT_W-1:0] two_dist;
    logic [rpfc_pkg::CNT_W-1:0] three_four;
    logic                       err;
  } census_t;

  class census_board;
    census_t pending[$];
    int mismatches;
    int unsigned rem[SPAN_MAX];
    bit [rpfc_pkg::TOT_W-1:0] tot[SPAN_MAX];
    bit [rpfc_pkg::DIS_W-1:0] dis[SPAN_MAX];
    bit prime_flag[FLAG_DEPTH];

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, t, b;
      r = 0;
      for (b = 64'd1 << 16; b != 0; b = b >> 1) begin
        t = r | b;
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function census_t census(logic [VB-1:0] lo_in, logic [VB-1:0] hi_in);
      census_t c;
      longint unsigned lo, hi, span, lim, i, p, x, first, v;
      int unsigned n23, npr, n2d, n34;
      lo = lo_in;
      hi = hi_in;
      c = '0;
      n23 = 0; npr = 0; n2d = 0; n34 = 0;
      if (hi < lo || hi - lo + 1 > SPAN_MAX) begin
        c.err = 1'b1;
        return c;
      end
      span = hi - lo + 1;
      for (i = 0; i < span; i++) begin
        rem[i] = 32'(lo + i);
        tot[i] = '0;
        dis[i] = '0;
      end
      lim = isqrt(hi) + 1;
      if (lim > FLAG_DEPTH - 1) lim = FLAG_DEPTH - 1;
      for (i = 0; i <= lim; i++) prime_flag[i] = (i >= 2);
      for (i = 2; i * i <= lim; i++)
        if (prime_flag[i])
          for (x = i * i; x <= lim; x += i) prime_flag[x] = 1'b0;
      for (p = 2; p <= lim; p++) begin
        if (!prime_flag[p]) continue;
        first = (lo + p - 1) / p * p;
        if (first < p * p) first = p * p;
        for (x = first; x <= hi; x += p) begin
          i = x - lo;
          if (i >= SPAN_MAX) break;
          if (rem[i] % p == 0 && rem[i] != 0) begin
            dis[i] = dis[i] + 1'b1;
            while (rem[i] % p == 0) begin
              rem[i] = 32'(rem[i] / p);
              tot[i] = tot[i] + 1'b1;
            end
          end
        end
      end
      for (i = 0; i < span; i++) begin
        v = lo + i;
        if (rem[i] > 1) begin
          dis[i] = dis[i] + 1'b1;
          tot[i] = tot[i] + 1'b1;
        end
        if (v % 2 == 0 || v % 3 == 0) n23++;
        if (v >= 2 && tot[i] == 1 && dis[i] == 1) npr++;
        if (tot[i] == 2 && dis[i] == 2) n2d++;
        if (tot[i] == 3 || tot[i] == 4) n34++;
      end
      c.div23 = n23[rpfc_pkg::CNT_W-1:0];
      c.primes = npr[rpfc_pkg::CNT_W-1:0];
      c.two_dist = n2d[rpfc_pkg::CNT_W-1:0];
      c.three_four = n34[rpfc_pkg::CNT_W-1:0];
      return c;
    endfunction

    function void note_item(logic [VB-1:0] lo, logic [VB-1:0] hi);
      pending = {pending, census(lo, hi)};
    endfunction

    function void check_result(census_t got);
      census_t exp_c;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_c, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [VB-1:0] range_start = '0;
  logic [VB-1:0] range_end = '0;
  logic busy, valid, range_error;
  logic [rpfc_pkg::CNT_W-1:0] count_div_two_or_three, prime_count;
  logic [rpfc_pkg::CNT_W-1:0] count_two_distinct, count_three_or_four;

  census_board board = new();

  range_prime_factor_census_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .range_start(range_start), .range_end(range_end), .valid(valid),
    .count_div_two_or_three(count_div_two_or_three), .prime_count(prime_count),
    .count_two_distinct(count_two_distinct), .count_three_or_four(count_three_or_four),
    .range_error(range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && valid)
      board.check_result({count_div_two_or_three, prime_count, count_two_distinct,
                          count_three_or_four, range_error});
  end

  // hold start until the unit takes the item, then release at the next falling edge
  task automatic send_item(logic [VB-1:0] lo, logic [VB-1:0] hi, bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(2) == 0) begin
      gap = $urandom_range(10, 1);
      repeat (gap) @(negedge clk);
    end
    range_start = lo;
    range_end = hi;
    start = 1'b1;
    do @(posedge clk); while (busy);
    board.note_item(lo, hi);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_random(bit allow_idle);
    logic [VB-1:0] lo, hi;
    int kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      lo = VB'($urandom);
      hi = VB'($urandom);
      if (hi >= lo && hi - lo < SPAN_MAX) hi = lo - 1'b1;
      if (hi >= lo) lo = hi + 1'b1;
    end else if (kind < 17) begin
      lo = VB'($urandom_range(TOP - 2000));
      hi = VB'(lo + SPAN_MAX + $urandom_range(500));
    end else if (kind < 20) begin
      lo = VB'($urandom_range(TOP - 40, TOP - 400000));
      lo = lo | VB'($urandom & 24'h00ffff);
      if (lo > TOP - 40) lo = VB'(TOP - 40);
      hi = VB'(lo + $urandom_range(32));
    end else begin
      lo = VB'($urandom_range(kind < 60 ? 2000 : 60000));
      hi = VB'(lo + $urandom_range(kind < 90 ? 48 : 300));
    end
    send_item(lo, hi, allow_idle);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_item(24'd0, 24'd0, 1'b1);
    send_item(24'd0, 24'd1, 1'b1);
    send_item(24'd1, 24'd1, 1'b0);
    send_item(24'd2, 24'd2, 1'b0);
    send_item(24'd4, 24'd4, 1'b1);
    send_item(24'd97, 24'd97, 1'b0);
    send_item(24'd30, 24'd30, 1'b1);
    send_item(24'd210, 24'd210, 1'b0);
    send_item(24'd0, 24'd30, 1'b1);
    send_item(24'd5, 24'd4, 1'b0);
    send_item(TOP, 24'd0, 1'b1);
    send_item(24'd0, VB'(SPAN_MAX), 1'b0);
    send_item(24'd100, VB'(100 + SPAN_MAX), 1'b1);
    send_item(24'd0, VB'(SPAN_MAX - 1), 1'b0);
    send_item(24'd1000, 24'd1100, 1'b1);
    send_item(24'h100000, 24'h100004, 1'b0);
    send_item(24'haaaaaa, 24'haaaaba, 1'b1);
    send_item(24'h555555, 24'h555565, 1'b0);
    send_item(TOP, TOP, 1'b1);
    send_item(VB'(TOP - SPAN_MAX + 1), TOP, 1'b0);
    for (int k = 0; k < 80; k++) send_random(k < 60);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #400000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
